>>> hdl/dpb_pkg.sv
// Package for the depth-to-point back-projection block.
// Holds the widths, register codes, reset values and payload structs.
// No dependencies; every other file of the block uses it.
`default_nettype none

package dpb_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int CNT_W      = $clog2(MAX_DIM);
	localparam int DIM_W      = CNT_W + 1;
	localparam int DEPTH_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int FOCAL_W    = 25;
	localparam int COORD_W    = 32;
	localparam int FRAC_SHIFT = 20;
	localparam int PROD1_W    = CNT_W + DEPTH_W;
	localparam int PROD2_W    = PROD1_W + FOCAL_W;
	localparam int QMAG_W     = PROD2_W - FRAC_SHIFT;

	// queue depths, powers of two
	localparam int CMD_DEPTH  = 4;
	localparam int OUT_DEPTH  = 8;
	localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;

	typedef logic [DIM_W-1:0]           dim_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic signed [CNT_W:0]      off_t;
	typedef logic [FOCAL_W-1:0]         focal_t;
	typedef logic [PROD1_W-1:0]         prod1_t;
	typedef logic [PROD2_W-1:0]         prod2_t;
	typedef logic [QMAG_W-1:0]          qmag_t;
	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [OUT_CNT_W-1:0]       out_cnt_t;

	localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_INV_FOCAL    = 2'd2;

	localparam dim_t   RST_IMAGE_WIDTH  = 13'd640;
	localparam dim_t   RST_IMAGE_HEIGHT = 13'd480;
	localparam focal_t RST_INV_FOCAL    = 25'd31957;

	localparam qmag_t  COORD_LIMIT = 33'd2147450880;
	localparam prod2_t ROUND_ADD   = prod2_t'((64'd1 << FRAC_SHIFT) - 64'd1);

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_mm;
		logic [COLOR_W-1:0] blue_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] red_in;
	} pixel_t;

	// fields that ride along the arithmetic unchanged
	typedef struct packed {
		logic [DEPTH_W-1:0] point_z;
		logic               point_valid;
		logic [COLOR_W-1:0] blue_out;
		logic [COLOR_W-1:0] green_out;
		logic [COLOR_W-1:0] red_out;
		logic               frame_last;
	} attr_t;

	typedef struct packed {
		off_t  offset_x;
		off_t  offset_y;
		attr_t attr;
	} cmd_t;

	typedef struct packed {
		coord_t             point_x;
		coord_t             point_y;
		logic [DEPTH_W-1:0] point_z;
		logic               point_valid;
		logic [COLOR_W-1:0] blue_out;
		logic [COLOR_W-1:0] green_out;
		logic [COLOR_W-1:0] red_out;
		logic               frame_last;
	} point_t;

endpackage

`default_nettype wire

>>> hdl/dpb_front.sv
// Front end: raster position counters and pixel classification.
// Turns each accepted pixel into a command for the back end.
// Depends on dpb_pkg.
`default_nettype none

module dpb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  dpb_pkg::pixel_t pixel,
	input  dpb_pkg::dim_t   image_width,
	input  dpb_pkg::dim_t   image_height,
	output dpb_pkg::cmd_t   cmd
);

	dpb_pkg::cnt_t col_q, row_q;
	dpb_pkg::dim_t w, h;
	dpb_pkg::cnt_t w_last, h_last, col_eff, row_eff;
	logic          col_end, row_end, depth_nz;

	always_comb begin
		if (image_width == '0) begin
			w = dpb_pkg::dim_t'(1);
		end else if (image_width > dpb_pkg::dim_t'(dpb_pkg::MAX_DIM)) begin
			w = dpb_pkg::dim_t'(dpb_pkg::MAX_DIM);
		end else begin
			w = image_width;
		end
		if (image_height == '0) begin
			h = dpb_pkg::dim_t'(1);
		end else if (image_height > dpb_pkg::dim_t'(dpb_pkg::MAX_DIM)) begin
			h = dpb_pkg::dim_t'(dpb_pkg::MAX_DIM);
		end else begin
			h = image_height;
		end
		w_last  = dpb_pkg::cnt_t'(w - dpb_pkg::dim_t'(1));
		h_last  = dpb_pkg::cnt_t'(h - dpb_pkg::dim_t'(1));
		// counters past the end (dimension lowered mid-frame) sit at the end
		col_eff = (col_q > w_last) ? w_last : col_q;
		row_eff = (row_q > h_last) ? h_last : row_q;
		col_end = (col_eff == w_last);
		row_end = (row_eff == h_last);
	end

	always_comb begin
		depth_nz = (pixel.depth_mm != '0);
		cmd.offset_x = dpb_pkg::off_t'({1'b0, col_eff})
			- dpb_pkg::off_t'({1'b0, w[dpb_pkg::DIM_W-1:1]});
		cmd.offset_y = dpb_pkg::off_t'({1'b0, row_eff})
			- dpb_pkg::off_t'({1'b0, h[dpb_pkg::DIM_W-1:1]});
		cmd.attr.point_z     = pixel.depth_mm;
		cmd.attr.point_valid = depth_nz;
		cmd.attr.blue_out    = depth_nz ? pixel.blue_in  : '0;
		cmd.attr.green_out   = depth_nz ? pixel.green_in : '0;
		cmd.attr.red_out     = depth_nz ? pixel.red_in   : '0;
		cmd.attr.frame_last  = col_end & row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_eff + dpb_pkg::cnt_t'(1);
			end else begin
				col_q <= col_eff + dpb_pkg::cnt_t'(1);
				row_q <= row_eff;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/dpb_cmd_queue.sv
// Command queue between front and back end.
// Register-based FIFO of dpb_pkg::cmd_t, depth dpb_pkg::CMD_DEPTH.
// Depends on dpb_pkg.
`default_nettype none

module dpb_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dpb_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output dpb_pkg::cmd_t head
);

	localparam int PTR_W = $clog2(dpb_pkg::CMD_DEPTH);
	localparam int CNT_W = $clog2(dpb_pkg::CMD_DEPTH + 1);

	dpb_pkg::cmd_t    entries_q [dpb_pkg::CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(dpb_pkg::CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> hdl/dpb_back.sv
// Back end: three-stage projection pipeline for X and Y.
// Stage 1 offset*depth, stage 2 times inverse focal, stage 3 shift and saturate.
// Depends on dpb_pkg.
`default_nettype none

module dpb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_avail,
	input  dpb_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	input  dpb_pkg::focal_t   inv_focal,
	input  dpb_pkg::out_cnt_t out_count,
	output logic              out_push,
	output dpb_pkg::point_t   out_data
);

	function automatic dpb_pkg::coord_t project(dpb_pkg::prod2_t p, logic neg);
		dpb_pkg::prod2_t adj;
		dpb_pkg::qmag_t  q;
		dpb_pkg::qmag_t  qs;
		dpb_pkg::qmag_t  qn;
		adj = neg ? p + dpb_pkg::ROUND_ADD : p;
		q   = adj[dpb_pkg::PROD2_W-1:dpb_pkg::FRAC_SHIFT];
		qs  = (q > dpb_pkg::COORD_LIMIT) ? dpb_pkg::COORD_LIMIT : q;
		qn  = -qs;
		return neg ? dpb_pkg::coord_t'(qn[dpb_pkg::COORD_W-1:0])
			: dpb_pkg::coord_t'(qs[dpb_pkg::COORD_W-1:0]);
	endfunction

	localparam int SUM_W = dpb_pkg::OUT_CNT_W + 1;

	logic              v_s1, v_s2, v_s3;
	dpb_pkg::prod1_t   px_s1, py_s1;
	dpb_pkg::prod2_t   px_s2, py_s2;
	dpb_pkg::coord_t   x_s3, y_s3;
	logic              nx_s1, ny_s1, nx_s2, ny_s2;
	dpb_pkg::attr_t    attr_s1, attr_s2, attr_s3;
	dpb_pkg::off_t     abs_x, abs_y;
	logic [SUM_W-1:0]  committed;

	// results in flight plus results queued must leave room in the output queue
	always_comb begin
		committed = SUM_W'(out_count) + SUM_W'(v_s1) + SUM_W'(v_s2) + SUM_W'(v_s3);
		cmd_pop   = cmd_avail && (committed < SUM_W'(dpb_pkg::OUT_DEPTH));
		abs_x     = cmd.offset_x[dpb_pkg::CNT_W] ? -cmd.offset_x : cmd.offset_x;
		abs_y     = cmd.offset_y[dpb_pkg::CNT_W] ? -cmd.offset_y : cmd.offset_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= dpb_pkg::prod1_t'(abs_x[dpb_pkg::CNT_W-1:0])
			* dpb_pkg::prod1_t'(cmd.attr.point_z);
		py_s1   <= dpb_pkg::prod1_t'(abs_y[dpb_pkg::CNT_W-1:0])
			* dpb_pkg::prod1_t'(cmd.attr.point_z);
		nx_s1   <= cmd.offset_x[dpb_pkg::CNT_W];
		ny_s1   <= cmd.offset_y[dpb_pkg::CNT_W];
		attr_s1 <= cmd.attr;

		px_s2   <= dpb_pkg::prod2_t'(px_s1) * dpb_pkg::prod2_t'(inv_focal);
		py_s2   <= dpb_pkg::prod2_t'(py_s1) * dpb_pkg::prod2_t'(inv_focal);
		nx_s2   <= nx_s1;
		ny_s2   <= ny_s1;
		attr_s2 <= attr_s1;

		x_s3    <= project(px_s2, nx_s2);
		y_s3    <= project(py_s2, ny_s2);
		attr_s3 <= attr_s2;
	end

	always_comb begin
		out_push             = v_s3;
		out_data.point_x     = x_s3;
		out_data.point_y     = y_s3;
		out_data.point_z     = attr_s3.point_z;
		out_data.point_valid = attr_s3.point_valid;
		out_data.blue_out    = attr_s3.blue_out;
		out_data.green_out   = attr_s3.green_out;
		out_data.red_out     = attr_s3.red_out;
		out_data.frame_last  = attr_s3.frame_last;
	end

endmodule

`default_nettype wire

>>> hdl/dpb_out_queue.sv
// Result queue in front of the output port.
// Register-based FIFO of dpb_pkg::point_t, depth dpb_pkg::OUT_DEPTH.
// Depends on dpb_pkg.
`default_nettype none

module dpb_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dpb_pkg::point_t   push_data,
	input  logic              pop,
	output logic              empty,
	output dpb_pkg::point_t   head,
	output dpb_pkg::out_cnt_t count
);

	localparam int PTR_W = $clog2(dpb_pkg::OUT_DEPTH);

	dpb_pkg::point_t   entries_q [dpb_pkg::OUT_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	dpb_pkg::out_cnt_t count_q;
	logic              do_push, do_pop;

	assign empty   = (count_q == '0);
	assign do_push = push && (count_q != dpb_pkg::out_cnt_t'(dpb_pkg::OUT_DEPTH));
	assign do_pop  = pop & ~empty;
	assign head    = entries_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + dpb_pkg::out_cnt_t'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - dpb_pkg::out_cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> hdl/depth_to_point_backprojection_top.sv
// Top level of the depth-to-point back-projection block.
// Instantiates dpb_front, dpb_cmd_queue, dpb_back and dpb_out_queue;
// depends on dpb_pkg.
//
// Usage:
//   Pixels enter in raster order on a queue-style port: a transaction
//   happens when push is high and full is low. Points leave the same way:
//   the oldest point is on 'point' while empty is low and is taken when
//   pop is high. Every pixel gives exactly one point.
//   Configuration (width, height, inverse focal) is written through
//   cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write only
//   while the block is idle.
//   An accepted pixel passes the command queue, then three pipeline
//   stages (offset times depth, times inverse focal, shift/saturate),
//   then the result queue, where empty goes low. Throughput is one pixel
//   per cycle, limited by the single issue slot and room in the result queue.
//   If pop stays low, the 8-entry result queue fills, issue into the
//   pipeline stops, the 4-entry command queue fills and full rises.
//   Reset (arst_n low) clears the raster counters and all queues and
//   loads the registers with 640 x 480 and an inverse focal of 31957.
`default_nettype none

module depth_to_point_backprojection_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  dpb_pkg::pixel_t           pixel,
	output logic                      empty,
	input  logic                      pop,
	output dpb_pkg::point_t           point,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  dpb_pkg::cfg_idx_t         cfg_index,
	input  logic [dpb_pkg::FOCAL_W-1:0] cfg_data
);

	dpb_pkg::dim_t     image_width_q, image_height_q;
	dpb_pkg::focal_t   inv_focal_q;
	dpb_pkg::cmd_t     front_cmd, head_cmd;
	logic              accept, cmd_empty, cmd_pop;
	logic              out_push;
	dpb_pkg::point_t   out_data;
	dpb_pkg::out_cnt_t out_count;

	assign cfg_ready = 1'b1;
	assign accept    = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= dpb_pkg::RST_IMAGE_WIDTH;
			image_height_q <= dpb_pkg::RST_IMAGE_HEIGHT;
			inv_focal_q    <= dpb_pkg::RST_INV_FOCAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dpb_pkg::CFG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[dpb_pkg::DIM_W-1:0];
				end
				dpb_pkg::CFG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[dpb_pkg::DIM_W-1:0];
				end
				dpb_pkg::CFG_INV_FOCAL: begin
					inv_focal_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	dpb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pixel        (pixel),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.cmd          (front_cmd)
	);

	dpb_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.full      (full),
		.pop       (cmd_pop),
		.empty     (cmd_empty),
		.head      (head_cmd)
	);

	dpb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (~cmd_empty),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.inv_focal (inv_focal_q),
		.out_count (out_count),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	dpb_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_push),
		.push_data (out_data),
		.pop       (pop),
		.empty     (empty),
		.head      (point),
		.count     (out_count)
	);

`ifndef NO_ASSERTIONS
	// the issue credit must keep the result queue from overflowing
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_count != dpb_pkg::out_cnt_t'(dpb_pkg::OUT_DEPTH)) || pop)
		else $error("result queue overflow");

	// the back end only issues from a non-empty command queue
	a_issue_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("issue from empty command queue");

	// an invalid point carries zero coordinates and colour
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !point.point_valid) |->
		(point.point_x == '0) && (point.point_y == '0) && (point.point_z == '0) &&
		(point.blue_out == '0) && (point.green_out == '0) && (point.red_out == '0))
		else $error("invalid point with nonzero payload");
`endif

endmodule

`default_nettype wire

>>> tb/depth_to_point_backprojection_top_tb.sv
// Self-checking testbench for depth_to_point_backprojection_top: raster pixels in,
// projected points out, each compared with a point computed here from the same pixel.
// Depends on dpb_pkg and the block's RTL.

module depth_to_point_backprojection_top_tb;

	import dpb_pkg::*;

	localparam int       CYCLE_LIMIT = 400000;
	localparam cfg_idx_t CFG_UNUSED  = 2'd3;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     push      = 1'b0;
	pixel_t   pixel     = '0;
	logic     pop       = 1'b0;
	logic     cfg_valid = 1'b0;
	cfg_idx_t cfg_index = CFG_IMAGE_WIDTH;
	focal_t   cfg_data  = '0;
	logic     full;
	logic     empty;
	logic     cfg_ready;
	point_t   point;

	// local copy of the block's registers and raster counters
	dim_t   img_w     = RST_IMAGE_WIDTH;
	dim_t   img_h     = RST_IMAGE_HEIGHT;
	focal_t inv_focal = RST_INV_FOCAL;
	cnt_t   col_cnt   = '0;
	cnt_t   row_cnt   = '0;

	pixel_t pending_pixels[$];
	point_t expected_points[$];
	point_t want_point;

	int          mismatches  = 0;
	int          points_seen = 0;
	int          cycles      = 0;
	int          burst_left  = 8;
	int          gap_left    = 0;
	int          pop_phase   = 0;
	logic [31:0] pop_mask    = '1;
	bit          steady      = 1'b0;

	depth_to_point_backprojection_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.point     (point),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// floor(offset * depth * inv_focal / 2^20), saturated
	function automatic coord_t axis_coord(longint offset, logic [DEPTH_W-1:0] depth);
		longint unsigned q;
		q = longint'(offset < 0 ? -offset : offset) * longint'(depth) * longint'(inv_focal);
		if (offset < 0) begin
			q = (q + ((64'd1 << FRAC_SHIFT) - 64'd1)) >> FRAC_SHIFT;
		end else begin
			q = q >> FRAC_SHIFT;
		end
		if (q > longint'(COORD_LIMIT)) begin
			q = longint'(COORD_LIMIT);
		end
		return (offset < 0) ? coord_t'(-longint'(q)) : coord_t'(q);
	endfunction

	function automatic point_t project_pixel(pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		bit          col_end;
		bit          row_end;
		point_t      pt;
		w = (img_w == 0) ? 1 : ((img_w > MAX_DIM) ? MAX_DIM : img_w);
		h = (img_h == 0) ? 1 : ((img_h > MAX_DIM) ? MAX_DIM : img_h);
		c = (col_cnt > w - 1) ? w - 1 : col_cnt;
		r = (row_cnt > h - 1) ? h - 1 : row_cnt;
		col_end = (c == w - 1);
		row_end = (r == h - 1);
		pt = '0;
		if (px.depth_mm != 0) begin
			pt.point_x     = axis_coord(longint'(c) - longint'(w >> 1), px.depth_mm);
			pt.point_y     = axis_coord(longint'(r) - longint'(h >> 1), px.depth_mm);
			pt.point_z     = px.depth_mm;
			pt.point_valid = 1'b1;
			pt.blue_out    = px.blue_in;
			pt.green_out   = px.green_in;
			pt.red_out     = px.red_in;
		end
		pt.frame_last = col_end && row_end;
		if (col_end) begin
			col_cnt = '0;
			row_cnt = row_end ? '0 : cnt_t'(r + 1);
		end else begin
			col_cnt = cnt_t'(c + 1);
			row_cnt = cnt_t'(r);
		end
		return pt;
	endfunction

	function automatic pixel_t random_pixel(bit far);
		logic [DEPTH_W-1:0] d;
		if (far) begin
			d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF - 16'($urandom_range(0, 3));
		end else begin
			case ($urandom_range(0, 7))
				0: d = '0;
				1: d = '1;
				2: d = 16'($urandom_range(1, 15));
				default: d = 16'($urandom);
			endcase
		end
		return {d, 8'($urandom), 8'($urandom), 8'($urandom)};
	endfunction

	function automatic focal_t random_dim();
		focal_t d;
		case ($urandom_range(0, 9))
			0: d = '0;
			1: d = 25'd1;
			2: d = focal_t'(MAX_DIM);
			3: d = focal_t'($urandom_range(MAX_DIM + 1, 8191));
			4, 5: d = focal_t'($urandom_range(2, 64));
			default: d = focal_t'($urandom_range(1, 8));
		endcase
		// bits above the register width must be dropped
		if ($urandom_range(0, 7) == 0) begin
			d[FOCAL_W-1:DIM_W] = 12'($urandom);
		end
		return d;
	endfunction

	function automatic focal_t random_focal();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return '1;
			2: return 25'd16777216;
			3: return RST_INV_FOCAL;
			default: return focal_t'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_pixels.size() != 0 || push || expected_points.size() != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, focal_t value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_IMAGE_WIDTH:  img_w = value[DIM_W-1:0];
			CFG_IMAGE_HEIGHT: img_h = value[DIM_W-1:0];
			CFG_INV_FOCAL:    inv_focal = value;
			default: ;
		endcase
	endtask

	task automatic run_phase(focal_t w, focal_t h, focal_t f, int n, bit far, bit calm);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_INV_FOCAL, f);
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_UNUSED, focal_t'($urandom));
		end
		steady = calm;
		repeat (n) pending_pixels = {pending_pixels, random_pixel(far)};
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10) begin
				$display("point %0d %s: expected 0x%h, actual 0x%h", points_seen, name, want, got);
			end
			mismatches++;
		end
	endtask

	// pixel driver: bursts with random gaps, item held while full
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				expected_points = {expected_points, project_pixel(pending_pixels.pop_front())};
				if (burst_left > 0) begin
					burst_left--;
				end
				if (burst_left == 0 && !steady) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = $urandom_range(0, 7);
				end
			end
			if (!(push && full)) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					push  <= 1'b1;
					pixel <= pending_pixels[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// point monitor with its own pop pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_points.size() == 0) begin
					if (mismatches < 10) begin
						$display("point %0d arrived with none expected", points_seen);
					end
					mismatches++;
				end else begin
					want_point = expected_points.pop_front();
					check_field("point_x", want_point.point_x, point.point_x);
					check_field("point_y", want_point.point_y, point.point_y);
					check_field("point_z", 32'(want_point.point_z), 32'(point.point_z));
					check_field("point_valid", 32'(want_point.point_valid), 32'(point.point_valid));
					check_field("blue_out", 32'(want_point.blue_out), 32'(point.blue_out));
					check_field("green_out", 32'(want_point.green_out), 32'(point.green_out));
					check_field("red_out", 32'(want_point.red_out), 32'(point.red_out));
					check_field("frame_last", 32'(want_point.frame_last), 32'(point.frame_last));
				end
				points_seen++;
			end
			if (pop_phase == 0) begin
				case ($urandom_range(0, 3))
					0: pop_mask = '1;
					1: pop_mask = $urandom;
					2: pop_mask = $urandom & $urandom & $urandom;
					default: pop_mask = $urandom | $urandom;
				endcase
				pop_phase = 31;
			end else begin
				pop_phase--;
			end
			pop <= steady | pop_mask[pop_phase];
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset values of the registers
		pending_pixels = {pending_pixels, pixel_t'({16'd0, 8'hFF, 8'hFF, 8'hFF})};
		pending_pixels = {pending_pixels, pixel_t'({16'hFFFF, 8'h00, 8'h00, 8'h00})};
		pending_pixels = {pending_pixels, pixel_t'({16'd1, 8'hA5, 8'h5A, 8'h3C})};

		// zero dimensions act as one: every pixel ends a frame
		write_reg(CFG_IMAGE_WIDTH, '0);
		write_reg(CFG_IMAGE_HEIGHT, '0);
		write_reg(CFG_INV_FOCAL, '1);
		pending_pixels = {pending_pixels, pixel_t'({16'hFFFF, 8'h0F, 8'hF0, 8'h81})};
		pending_pixels = {pending_pixels, pixel_t'({16'd0, 8'h7E, 8'h18, 8'hC3})};

		// oversize dimensions clamp to the maximum; far corner saturates
		write_reg(CFG_IMAGE_WIDTH, '1);
		write_reg(CFG_IMAGE_HEIGHT, focal_t'(MAX_DIM));
		pending_pixels = {pending_pixels, pixel_t'({16'hFFFF, 8'h55, 8'hAA, 8'h01})};
		repeat (5) pending_pixels = {pending_pixels, random_pixel(1'b1)};

		// width lowered mid-row, unknown register ignored
		write_reg(CFG_IMAGE_WIDTH, 25'd3);
		write_reg(CFG_UNUSED, 25'h1555555);
		repeat (2) pending_pixels = {pending_pixels, random_pixel(1'b0)};

		// height lowered below the current row
		write_reg(CFG_IMAGE_WIDTH, 25'd1);
		repeat (4) pending_pixels = {pending_pixels, random_pixel(1'b0)};
		write_reg(CFG_IMAGE_HEIGHT, 25'd2);
		repeat (2) pending_pixels = {pending_pixels, random_pixel(1'b0)};

		for (int p = 0; p < 14; p++) begin
			run_phase(random_dim(), random_dim(), random_focal(), 50, 1'b0, p % 5 == 4);
		end

		// short sweeps of each axis at full inverse focal and far depth
		run_phase(25'd1, 25'd48, '1, 48, 1'b1, 1'b1);
		run_phase(25'd48, 25'd1, '1, 48, 1'b1, 1'b1);

		run_phase(RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_INV_FOCAL, 40, 1'b0, 1'b0);

		wait_idle();
		repeat (12) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
